/* rtl/tlg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tlg_pkg;

  localparam logic [7:0] SYM_MOVE  = 8'h46;  // 'F'
  localparam logic [7:0] SYM_LEFT  = 8'h2D;  // '-'
  localparam logic [7:0] SYM_RIGHT = 8'h2B;  // '+'

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 2'd3;

  localparam int STEP_W  = 20;
  localparam int ANGLE_W = 16;
  localparam int COORD_W = 24;
  localparam int TRIG_W  = 17;  // signed Q1.15, -32768..32768
  localparam int DELTA_W = 23;  // signed step * trig, rounded

  localparam logic [STEP_W-1:0]         STEP_RESET    = 20'd25600;
  localparam logic [ANGLE_W-1:0]        TURN_RESET    = 16'd10923;
  localparam logic signed [COORD_W-1:0] START_X_RESET = 24'sd25600;
  localparam logic signed [COORD_W-1:0] START_Y_RESET = 24'sd76800;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave sine entry k, Q1.15, from an integer Taylor series in Q30.
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned bits);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint unsigned q;
    x    = (HALF_PI_Q30 * longint'(k)) >> bits;
    term = x;
    sum  = longint'(x);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 6;
    sum  = sum - longint'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 20;
    sum  = sum + longint'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 42;
    sum  = sum - longint'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 72;
    sum  = sum + longint'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    q = (longint'(sum) + 64'd16384) >> 15;
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    return q[15:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tlg_sine.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlg_sine #(
  parameter int SINE_TABLE_BITS = 8
) (
  input  wire logic [tlg_pkg::ANGLE_W-1:0]       angle,
  output logic signed [tlg_pkg::TRIG_W-1:0]      sine
);
  import tlg_pkg::*;

  localparam int B   = SINE_TABLE_BITS;
  localparam int LEN = (1 << B) + 1;

  logic [15:0] rom [LEN];

  for (genvar k = 0; k < LEN; k++) begin : g_rom
    localparam logic [15:0] ENTRY = sine_entry(k, B);
    assign rom[k] = ENTRY;
  end

  logic [B-1:0] idx;
  logic [B:0]   rom_idx;
  logic [15:0]  mag;

  assign idx = angle[ANGLE_W-3 -: B];

  // odd quadrants read the table backwards
  always_comb begin
    if (angle[ANGLE_W-2]) begin
      rom_idx = ((B+1)'(1) << B) - {1'b0, idx};
    end else begin
      rom_idx = {1'b0, idx};
    end
  end

  assign mag  = rom[rom_idx];
  assign sine = angle[ANGLE_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

`default_nettype wire

/* rtl/tlg_scale.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlg_scale (
  input  wire logic [tlg_pkg::STEP_W-1:0]         step,
  input  wire logic signed [tlg_pkg::TRIG_W-1:0]  trig,
  output logic signed [tlg_pkg::DELTA_W-1:0]      delta
);
  import tlg_pkg::*;

  localparam int PROD_W = STEP_W + TRIG_W - 1;

  logic [TRIG_W-1:0]  trig_abs;
  logic [TRIG_W-2:0]  mag;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    rnd;
  logic [DELTA_W-2:0] p;

  assign trig_abs = trig[TRIG_W-1] ? 17'(-trig) : 17'(trig);
  assign mag      = trig_abs[TRIG_W-2:0];
  assign prod     = step * mag;
  // round half away from zero on the magnitude
  assign rnd      = {1'b0, prod} + (PROD_W+1)'(1 << 14);
  assign p        = rnd[PROD_W -: (DELTA_W-1)];
  assign delta    = trig[TRIG_W-1] ? -$signed({1'b0, p}) : $signed({1'b0, p});

endmodule

`default_nettype wire

/* rtl/turtle_line_generator.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------------------
// in        | in_valid / in_stall     | in_symbol
// out       | out_valid / out_stall   | out_draw, out_seg_start_x/y, out_seg_end_x/y
// cfg       | cfg_we                  | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; a request goes from the
// input register through one pass of decode, pen update and result register.
// The step vector is kept precomputed from the next heading and step length, so
// the pen loop closes through one 25-bit add and saturate per cycle.
// Reset (rst_n low, synchronous) empties both stages and loads pen and registers.
// A stalled result holds; the input stage stalls only while it holds a request.

module turtle_line_generator #(
  parameter int SINE_TABLE_BITS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,

  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [7:0]                            in_symbol,

  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_draw,
  output logic signed [tlg_pkg::COORD_W-1:0]         out_seg_start_x,
  output logic signed [tlg_pkg::COORD_W-1:0]         out_seg_start_y,
  output logic signed [tlg_pkg::COORD_W-1:0]         out_seg_end_x,
  output logic signed [tlg_pkg::COORD_W-1:0]         out_seg_end_y,

  input  wire logic                                  cfg_we,
  input  wire logic [tlg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [tlg_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import tlg_pkg::*;

  // configuration
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [ANGLE_W-1:0] turn_r;

  // turtle state
  logic signed [COORD_W-1:0] pen_x_r, pen_x_nxt;
  logic signed [COORD_W-1:0] pen_y_r, pen_y_nxt;
  logic [ANGLE_W-1:0]        heading_r, heading_nxt;
  logic signed [DELTA_W-1:0] dx_r, dy_r;

  // input stage
  logic       in_vld_r;
  logic [7:0] sym_r;

  // result stage
  logic                      out_vld_r;
  logic                      draw_r;
  logic signed [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;

  logic out_free, exec, do_move, do_left, do_right, in_acc;

  assign out_free = !out_vld_r || !out_stall;
  assign exec     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign do_move  = exec && (sym_r == SYM_MOVE);
  assign do_left  = exec && (sym_r == SYM_LEFT);
  assign do_right = exec && (sym_r == SYM_RIGHT);

  always_comb begin
    step_nxt = step_r;
    if (cfg_we && cfg_index == CFG_STEP_LENGTH) begin
      step_nxt = cfg_data[STEP_W-1:0];
    end
  end

  always_comb begin
    heading_nxt = heading_r;
    if (do_left) begin
      heading_nxt = heading_r + turn_r;
    end else if (do_right) begin
      heading_nxt = heading_r - turn_r;
    end
  end

  // step vector for the heading that the next request will see
  logic [ANGLE_W-1:0]        trig_heading, cos_angle;
  logic [STEP_W-1:0]         trig_step;
  logic signed [TRIG_W-1:0]  cos_v, sin_v;
  logic signed [DELTA_W-1:0] dx_nxt, dy_nxt;

  assign trig_heading = rst_n ? heading_nxt : '0;
  assign trig_step    = rst_n ? step_nxt : STEP_RESET;
  assign cos_angle    = trig_heading + QUARTER_TURN;

  tlg_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cos (
    .angle (cos_angle),
    .sine  (cos_v)
  );

  tlg_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sin (
    .angle (trig_heading),
    .sine  (sin_v)
  );

  tlg_scale u_scale_x (
    .step  (trig_step),
    .trig  (cos_v),
    .delta (dx_nxt)
  );

  tlg_scale u_scale_y (
    .step  (trig_step),
    .trig  (sin_v),
    .delta (dy_nxt)
  );

  logic signed [COORD_W:0]   sum_x, sum_y;
  logic signed [COORD_W-1:0] end_x, end_y;

  assign sum_x = {pen_x_r[COORD_W-1], pen_x_r} + (COORD_W+1)'(dx_r);
  assign sum_y = {pen_y_r[COORD_W-1], pen_y_r} - (COORD_W+1)'(dy_r);
  assign end_x = sat_coord(sum_x);
  assign end_y = sat_coord(sum_y);

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (cfg_we && cfg_index == CFG_START_X) begin
      pen_x_nxt = cfg_data[COORD_W-1:0];
    end else if (do_move) begin
      pen_x_nxt = end_x;
    end
    if (cfg_we && cfg_index == CFG_START_Y) begin
      pen_y_nxt = cfg_data[COORD_W-1:0];
    end else if (do_move) begin
      pen_y_nxt = end_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_RESET;
      turn_r    <= TURN_RESET;
      pen_x_r   <= START_X_RESET;
      pen_y_r   <= START_Y_RESET;
      heading_r <= '0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      if (cfg_we && cfg_index == CFG_TURN_ANGLE) begin
        turn_r <= cfg_data[ANGLE_W-1:0];
      end
      pen_x_r   <= pen_x_nxt;
      pen_y_r   <= pen_y_nxt;
      heading_r <= heading_nxt;
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (exec) begin
        in_vld_r <= 1'b0;
      end
      if (exec) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // start_x/start_y are not kept: they only load the pen
  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    if (in_acc) begin
      sym_r <= in_symbol;
    end
    if (exec) begin
      draw_r <= do_move;
      sx_r   <= do_move ? pen_x_r : '0;
      sy_r   <= do_move ? pen_y_r : '0;
      ex_r   <= do_move ? end_x : '0;
      ey_r   <= do_move ? end_y : '0;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_draw        = draw_r;
  assign out_seg_start_x = sx_r;
  assign out_seg_start_y = sy_r;
  assign out_seg_end_x   = ex_r;
  assign out_seg_end_y   = ey_r;

  ap_exec_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_vld_r)
    else $error("executed request did not reach the result register");

  ap_heading_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !do_left && !do_right |=> $stable(heading_r))
    else $error("heading changed without a turn");

  ap_pen_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !do_move && !cfg_we |=> $stable(pen_x_r) && $stable(pen_y_r))
    else $error("pen moved without a move request");

  ap_no_draw_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !draw_r |-> sx_r == '0 && sy_r == '0 && ex_r == '0 && ey_r == '0)
    else $error("non-draw result carries coordinates");

  ap_stall_holds_item : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_vld_r && $stable(sym_r))
    else $error("stalled input stage lost its request");

endmodule

`default_nettype wire

/* tb/turtle_checker.sv */
`timescale 1ns / 1ps

module turtle_checker #(
  parameter int TABLE_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [7:0]                            in_symbol,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic                                  out_draw,
  input  logic signed [tlg_pkg::COORD_W-1:0]    out_seg_start_x,
  input  logic signed [tlg_pkg::COORD_W-1:0]    out_seg_start_y,
  input  logic signed [tlg_pkg::COORD_W-1:0]    out_seg_end_x,
  input  logic signed [tlg_pkg::COORD_W-1:0]    out_seg_end_y,
  input  logic                                  cfg_we,
  input  logic [tlg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tlg_pkg::CFG_DATA_W-1:0]        cfg_data,
  output int                                    errors,
  output int                                    open_count
);

  import tlg_pkg::*;

  typedef struct {
    logic                      draw;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } segment_t;

  localparam int ROM_LEN = (1 << TABLE_BITS) + 1;

  longint unsigned           quarter_sine [ROM_LEN];
  logic [STEP_W-1:0]         step_len;
  logic [ANGLE_W-1:0]        turn;
  logic [ANGLE_W-1:0]        heading;
  logic signed [COORD_W-1:0] pen_x;
  logic signed [COORD_W-1:0] pen_y;
  segment_t                  expected_segments [$];
  segment_t                  want;
  int                        result_no;

  initial begin
    errors     = 0;
    open_count = 0;
    result_no  = 0;
  end

  // quarter wave: odd Taylor terms in Q30, each product truncated, then Q15
  initial begin : build_sine
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    longint unsigned q;
    for (int k = 0; k < ROM_LEN; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
      term = x;
      acc  = signed'(x);
      for (int n = 1; n <= 5; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - signed'(term);
        end else begin
          acc = acc + signed'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      q = (unsigned'(acc) + 64'd16384) >> 15;
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      quarter_sine[k] = q;
    end
  end

  function automatic int trig(input logic [ANGLE_W-1:0] a);
    logic [1:0] quad;
    int         idx;
    int         mag;
    quad = a[15:14];
    idx  = int'(a[13:0] >> (14 - TABLE_BITS));
    if (quad[0]) begin
      mag = int'(quarter_sine[(1 << TABLE_BITS) - idx]);
    end else begin
      mag = int'(quarter_sine[idx]);
    end
    return quad[1] ? -mag : mag;
  endfunction

  // step times Q1.15, magnitude rounded half up, sign put back after
  function automatic longint stretch(input int s);
    longint m;
    longint p;
    m = (s < 0) ? -longint'(s) : longint'(s);
    p = (longint'(step_len) * m + 64'sd16384) >>> 15;
    return (s < 0) ? -p : p;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp(input longint v);
    if (v > longint'(COORD_MAX)) begin
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic segment_t next_segment(input logic [7:0] sym);
    segment_t seg;
    int       c;
    int       s;
    seg = '{draw: 1'b0, start_x: '0, start_y: '0, end_x: '0, end_y: '0};
    if (sym == SYM_MOVE) begin
      c           = trig(heading + QUARTER_TURN);
      s           = trig(heading);
      seg.draw    = 1'b1;
      seg.start_x = pen_x;
      seg.start_y = pen_y;
      seg.end_x   = clamp(longint'(pen_x) + stretch(c));
      seg.end_y   = clamp(longint'(pen_y) - stretch(s));
      pen_x       = seg.end_x;
      pen_y       = seg.end_y;
    end else if (sym == SYM_LEFT) begin
      heading = heading + turn;
    end else if (sym == SYM_RIGHT) begin
      heading = heading - turn;
    end
    return seg;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors = errors + 1;
  endtask

  task automatic check_field(input string name, input longint got, input longint exp_val);
    if (got != exp_val) begin
      report($sformatf("result %0d: %s is %0d, expected %0d", result_no, name, got, exp_val));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_len = STEP_RESET;
      turn     = TURN_RESET;
      pen_x    = START_X_RESET;
      pen_y    = START_Y_RESET;
      heading  = '0;
      expected_segments.delete();
      open_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_LENGTH: step_len = cfg_data[STEP_W-1:0];
          CFG_TURN_ANGLE:  turn     = cfg_data[ANGLE_W-1:0];
          CFG_START_X:     pen_x    = cfg_data;
          CFG_START_Y:     pen_y    = cfg_data;
          default: ;
        endcase
      end
      // results first, so a request taken at this edge is never matched at it
      if (out_valid && !out_stall) begin
        if (expected_segments.size() == 0) begin
          report($sformatf("result %0d arrived with no request outstanding", result_no));
        end else begin
          want = expected_segments.pop_front();
          check_field("draw", longint'(out_draw), longint'(want.draw));
          check_field("seg_start_x", longint'(out_seg_start_x), longint'(want.start_x));
          check_field("seg_start_y", longint'(out_seg_start_y), longint'(want.start_y));
          check_field("seg_end_x", longint'(out_seg_end_x), longint'(want.end_x));
          check_field("seg_end_y", longint'(out_seg_end_y), longint'(want.end_y));
        end
        result_no = result_no + 1;
      end
      if (in_valid && !in_stall) begin
        expected_segments.push_back(next_segment(in_symbol));
      end
      open_count <= expected_segments.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  import tlg_pkg::*;

  localparam int TABLE_BITS  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 30;
  localparam int PHASE_ITEMS = 60;
  localparam int HOLD_CYCLES = 300;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic [7:0]                  in_symbol = 8'h00;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_draw;
  logic signed [COORD_W-1:0]   out_seg_start_x;
  logic signed [COORD_W-1:0]   out_seg_start_y;
  logic signed [COORD_W-1:0]   out_seg_end_x;
  logic signed [COORD_W-1:0]   out_seg_end_y;
  logic                        cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = CFG_STEP_LENGTH;
  logic [CFG_DATA_W-1:0]       cfg_data  = '0;
  int                          errors;
  int                          open_count;
  bit                          hold_req  = 1'b0;

  turtle_line_generator #(
    .SINE_TABLE_BITS(TABLE_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_draw        (out_draw),
    .out_seg_start_x (out_seg_start_x),
    .out_seg_start_y (out_seg_start_y),
    .out_seg_end_x   (out_seg_end_x),
    .out_seg_end_y   (out_seg_end_y),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  turtle_checker #(
    .TABLE_BITS(TABLE_BITS)
  ) watcher (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_draw        (out_draw),
    .out_seg_start_x (out_seg_start_x),
    .out_seg_start_y (out_seg_start_y),
    .out_seg_end_x   (out_seg_end_x),
    .out_seg_end_y   (out_seg_end_y),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .open_count      (open_count)
  );

  always #6 clk = ~clk;

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d requests outstanding", cycles, open_count);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: stall density changes per stretch; a long hold-off when asked
  initial begin : receiver
    int stall_pct;
    int stretch;
    forever begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 20;
        3:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      stretch = $urandom_range(10, 120);
      repeat (stretch) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic offer(input logic [7:0] sym);
    in_valid  <= 1'b1;
    in_symbol <= sym;
    do @(posedge clk); while (in_stall);
  endtask

  // open_count is registered, so never read it before waiting on the clock
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic configure(input bit [3:0] sel, input logic [23:0] step_v,
                           input logic [23:0] turn_v, input logic [23:0] x_v,
                           input logic [23:0] y_v);
    logic [CFG_IDX_W-1:0]  regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs = '{CFG_STEP_LENGTH, CFG_TURN_ANGLE, CFG_START_X, CFG_START_Y};
    vals = '{step_v, turn_v, x_v, y_v};
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= regs[i];
        cfg_data  <= vals[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;                     // upper bits are dropped
      2:       return 24'($urandom_range(1, 255));
      3:       return 24'($urandom_range(0, 65536));
      4:       return 24'($urandom);
      default: return 24'((1 << STEP_W) - 1);
    endcase
  endfunction

  function automatic logic [23:0] pick_turn();
    case ($urandom_range(0, 6))
      0:       return 24'd0;
      1:       return 24'd1;
      2:       return 24'(QUARTER_TURN);
      3:       return 24'h8000;
      4:       return 24'hFFFF;
      5:       return 24'($urandom_range(0, 65535));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return 24'd0;
      3:       return 24'($urandom_range(0, 200000)) - 24'd100000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return SYM_MOVE;
    end else if (r < 65) begin
      return SYM_LEFT;
    end else if (r < 85) begin
      return SYM_RIGHT;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    logic [7:0] dir_a [] = '{SYM_MOVE, SYM_LEFT, SYM_MOVE, SYM_RIGHT, SYM_RIGHT, SYM_MOVE,
                             SYM_LEFT, 8'h00, 8'hFF, 8'h45, 8'h47, 8'h2C, 8'h2A};
    logic [7:0] dir_b [] = '{SYM_MOVE, SYM_LEFT, SYM_MOVE, SYM_LEFT, SYM_LEFT, SYM_MOVE,
                             SYM_RIGHT, SYM_MOVE};
    logic [7:0] dir_c [] = '{SYM_LEFT, SYM_MOVE, SYM_RIGHT, SYM_RIGHT, SYM_MOVE};
    int  sent;
    int  burst;
    int  gap;
    bit  steady;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: plain moves, both turns, near-miss symbols
    foreach (dir_a[i]) offer(dir_a[i]);
    drain();
    // longest step from just inside the corners: end points clip
    configure(4'hF, 24'((1 << STEP_W) - 1), 24'(QUARTER_TURN),
              24'(COORD_MAX - 100), 24'(COORD_MIN + 100));
    foreach (dir_b[i]) offer(dir_b[i]);
    drain();
    // zero step, turn by all but one count
    configure(4'hF, 24'd0, 24'hFFFF, COORD_MIN, COORD_MAX);
    foreach (dir_c[i]) offer(dir_c[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      configure(4'($urandom_range(0, 15)), pick_step(), pick_turn(), pick_coord(),
                pick_coord());
      if (p == 2 || p == 17) begin
        hold_req = 1'b1;
      end
      steady = ($urandom_range(0, 4) == 0);
      sent   = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        if (burst > PHASE_ITEMS - sent) begin
          burst = PHASE_ITEMS - sent;
        end
        repeat (burst) begin
          offer(pick_symbol());
          sent++;
        end
        if (!steady) begin
          gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
